### rtl/rctn_pkg.sv
// ----------------------------------------------------------------------------
// rctn_pkg
// Shared types, register indexes and reset values for the throttle channel
// normalizer.
// ----------------------------------------------------------------------------
package rctn_pkg;

    // default width of the tracked samples
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int PULSE_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CHANGE_W = 17;
    localparam int CIDX_W   = 3;

    // largest reported change magnitude
    localparam int CHANGE_LIMIT = 65535;

    // configuration register indexes
    typedef logic [CIDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_MODE_RETURNING = 3'd0;
    localparam cfg_index_t REG_MIDDLE_POINT   = 3'd1;
    localparam cfg_index_t REG_DEAD_BAND      = 3'd2;
    localparam cfg_index_t REG_BOUND_SEED     = 3'd3;
    localparam cfg_index_t REG_OUT_FLOOR      = 3'd4;
    localparam cfg_index_t REG_OUT_CEILING    = 3'd5;

    // register reset values
    localparam logic              MODE_RETURNING_RST = 1'b1;
    localparam logic [CFG_W-1:0]  MIDDLE_POINT_RST   = 16'd1500;
    localparam logic [CFG_W-1:0]  DEAD_BAND_RST      = 16'd10;
    localparam logic [CFG_W-1:0]  BOUND_SEED_RST     = 16'd1500;
    localparam logic [CFG_W-1:0]  OUT_FLOOR_RST      = 16'd0;
    localparam logic [CFG_W-1:0]  OUT_CEILING_RST    = 16'd255;

    // input operation codes
    localparam logic OP_SAMPLE      = 1'b0;
    localparam logic OP_BOUND_RESET = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_FINISH,
        ST_DONE
    } state_t;

endpackage

### rtl/rctn_div.sv
// ----------------------------------------------------------------------------
// rctn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rctn_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_diff;
    logic                  qbit;
    logic [DIVISOR_W-1:0]  rem_next;

    // one trial subtraction per cycle
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial_diff = trial - {1'b0, dsr_reg};
        qbit       = ~trial_diff[DIVISOR_W];
        rem_next   = qbit ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/rc_throttle_channel_normalizer.sv
// ----------------------------------------------------------------------------
// rc_throttle_channel_normalizer
// Tracks the span of raw receiver pulse widths and reports a scaled throttle
// change against the stick center or the range floor.
// ----------------------------------------------------------------------------
// Usage:
//   s_* beats carry a command: tuser 0 is a new sample in tdata, tuser 1 reloads
//   the tracked bounds from bound_seed. Every command gives exactly one m_* beat
//   with the signed change and the empty-range flag. cfg_wr_en/cfg_index/cfg_wdata
//   write the six registers; user's rule: only while idle, not enforced by the block.
// Sequencing:
//   s_tready is high only in the idle state; one command is in work at a time.
//   A bound reload goes from idle straight to the done state; an empty range
//   or a change inside the dead band first passes the prep and check states.
//   A scaled change runs each division through one shared restoring divider,
//   one quotient bit per cycle; there is one division in fixed mode and two in
//   returning mode, each with a PROD_W-bit quotient, PROD_W = max(SAMPLE_BITS,16) + 16.
//   The next command is taken in the idle state that follows the result load.
// Reset:
//   registers return to their defaults, bounds to the default seed, samples
//   to zero; no beat is pending.
// Stall:
//   the result sits in an output register; while it waits the next command
//   can be taken and computed, and it holds in the done state until the
//   output register frees.
// ----------------------------------------------------------------------------
module rc_throttle_channel_normalizer #(
    parameter int SAMPLE_BITS = rctn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // command channel
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [15:0] pulse_width
    input  logic                     s_tuser,   // [0] operation
    // result channel
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,   // [16:0] throttle_change, [23:17] zero
    output logic                     m_tuser,   // [0] range_empty
    // configuration write port
    input  logic                     cfg_wr_en,
    input  rctn_pkg::cfg_index_t     cfg_index,
    input  logic [rctn_pkg::CFG_W-1:0] cfg_wdata
);

    import rctn_pkg::*;

    localparam int MAG_W  = (SAMPLE_BITS > PULSE_W) ? SAMPLE_BITS : PULSE_W;
    localparam int EXT_W  = MAG_W + 1;
    localparam int PROD_W = MAG_W + CFG_W;
    localparam int Q_W    = PROD_W + 1;
    localparam int DIFF_W = PROD_W + 2;

    localparam logic signed [DIFF_W-1:0] LIM_POS = DIFF_W'(CHANGE_LIMIT);
    localparam logic signed [DIFF_W-1:0] LIM_NEG = -DIFF_W'(CHANGE_LIMIT);
    localparam logic [SAMPLE_BITS-1:0]   SEED_RST_S = SAMPLE_BITS'(BOUND_SEED_RST);

    // configuration registers
    logic               mode_reg;
    logic [CFG_W-1:0]   middle_reg;
    logic [CFG_W-1:0]   dead_band_reg;
    logic [CFG_W-1:0]   seed_reg;
    logic [CFG_W-1:0]   floor_reg;
    logic [CFG_W-1:0]   ceiling_reg;

    // tracked state
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [SAMPLE_BITS-1:0] newest_reg;
    logic [SAMPLE_BITS-1:0] prev_reg;

    // sequencer
    state_t state_reg;
    state_t state_next;
    logic   phase_reg;

    // prepared operands
    logic               empty_reg;
    logic               pass_reg;
    logic [MAG_W-1:0]   n_off_reg;
    logic [MAG_W-1:0]   m_mag_reg;
    logic               m_neg_reg;
    logic [CFG_W-1:0]   os_mag_reg;
    logic               os_neg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               prod_neg_reg;
    logic signed [Q_W-1:0] q1_reg;
    logic signed [Q_W-1:0] q2_reg;

    // result and output registers
    logic [CHANGE_W-1:0] res_change_reg;
    logic                res_empty_reg;
    logic                m_tvalid_reg;
    logic [CHANGE_W-1:0] m_change_reg;
    logic                m_empty_reg;

    // handshake and sequencer outputs
    logic in_accept;
    logic out_free;
    logic div_start;
    logic out_load;
    logic div_done;
    logic [PROD_W-1:0] div_quo;

    // sample and seed cut to the tracked width
    logic [MAG_W-1:0]       pw_ext;
    logic [MAG_W-1:0]       seed_ext;
    logic [SAMPLE_BITS-1:0] sample_s;
    logic [SAMPLE_BITS-1:0] seed_s;

    // prep arithmetic
    logic signed [EXT_W-1:0] n_e;
    logic signed [EXT_W-1:0] lo_e;
    logic signed [EXT_W-1:0] ref_e;
    logic signed [EXT_W-1:0] mid_e;
    logic signed [EXT_W-1:0] d_ref;
    logic signed [EXT_W-1:0] md;
    logic [EXT_W-1:0]        ad_ref;
    logic [EXT_W-1:0]        ad_md;
    logic signed [CFG_W:0]   os;
    logic [CFG_W:0]          os_abs;

    // multiply, quotient sign and final difference
    logic [MAG_W-1:0]        mul_a;
    logic [PROD_W-1:0]       mul_p;
    logic signed [Q_W-1:0]   q_signed;
    logic signed [DIFF_W-1:0] change_d;
    logic [CHANGE_W-1:0]     change_sat;

    assign pw_ext   = MAG_W'(s_tdata);
    assign seed_ext = MAG_W'(seed_reg);
    assign sample_s = pw_ext[SAMPLE_BITS-1:0];
    assign seed_s   = seed_ext[SAMPLE_BITS-1:0];

    assign in_accept = s_tvalid & s_tready;
    assign out_free  = ~m_tvalid_reg | m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RETURNING_RST;
            middle_reg    <= MIDDLE_POINT_RST;
            dead_band_reg <= DEAD_BAND_RST;
            seed_reg      <= BOUND_SEED_RST;
            floor_reg     <= OUT_FLOOR_RST;
            ceiling_reg   <= OUT_CEILING_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE_RETURNING: mode_reg      <= cfg_wdata[0];
                REG_MIDDLE_POINT:   middle_reg    <= cfg_wdata;
                REG_DEAD_BAND:      dead_band_reg <= cfg_wdata;
                REG_BOUND_SEED:     seed_reg      <= cfg_wdata;
                REG_OUT_FLOOR:      floor_reg     <= cfg_wdata;
                REG_OUT_CEILING:    ceiling_reg   <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // bound tracking and sample history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= SEED_RST_S;
            max_reg    <= SEED_RST_S;
            newest_reg <= '0;
            prev_reg   <= '0;
        end
        else if (in_accept)
        begin
            if (s_tuser == OP_BOUND_RESET)
            begin
                min_reg <= seed_s;
                max_reg <= seed_s;
            end
            else
            begin
                if (sample_s < min_reg)
                    min_reg <= sample_s;
                if (sample_s > max_reg)
                    max_reg <= sample_s;
                prev_reg   <= newest_reg;
                newest_reg <= sample_s;
            end
        end
    end

    // differences and dead band test
    always_comb
    begin
        n_e    = $signed({1'b0, MAG_W'(newest_reg)});
        lo_e   = $signed({1'b0, MAG_W'(min_reg)});
        mid_e  = $signed({1'b0, MAG_W'(middle_reg)});
        ref_e  = mode_reg ? mid_e : $signed({1'b0, MAG_W'(prev_reg)});
        d_ref  = n_e - ref_e;
        ad_ref = d_ref[EXT_W-1] ? EXT_W'(-d_ref) : EXT_W'(d_ref);
        md     = mid_e - lo_e;
        ad_md  = md[EXT_W-1] ? EXT_W'(-md) : EXT_W'(md);
        os     = $signed({1'b0, ceiling_reg}) - $signed({1'b0, floor_reg});
        os_abs = os[CFG_W] ? (CFG_W+1)'(-os) : (CFG_W+1)'(os);
    end

    // shared multiplier, operand picked by phase
    assign mul_a = phase_reg ? m_mag_reg : n_off_reg;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(os_mag_reg);

    // signed quotient from the divider
    assign q_signed = prod_neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    // difference of the two mapped values, saturated
    always_comb
    begin
        change_d = DIFF_W'(q1_reg) - DIFF_W'(q2_reg);
        if (change_d > LIM_POS)
            change_sat = LIM_POS[CHANGE_W-1:0];
        else if (change_d < LIM_NEG)
            change_sat = LIM_NEG[CHANGE_W-1:0];
        else
            change_sat = change_d[CHANGE_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = (s_tuser == OP_BOUND_RESET) ? ST_DONE : ST_PREP;
            end
            ST_PREP:   state_next = ST_CHECK;
            ST_CHECK:  state_next = (empty_reg || !pass_reg) ? ST_DONE : ST_MUL;
            ST_MUL:    state_next = ST_DIV;
            ST_DIV:    state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_done)
                    state_next = (!phase_reg && mode_reg) ? ST_MUL : ST_FINISH;
            end
            ST_FINISH: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DIV);
        out_load  = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CHECK)
                phase_reg <= 1'b0;
            else if (state_reg == ST_WAIT && div_done)
                phase_reg <= 1'b1;
        end
    end

    // operand, product and quotient registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                res_change_reg <= '0;
                res_empty_reg  <= 1'b0;
            end
            ST_PREP:
            begin
                empty_reg  <= (max_reg == min_reg);
                pass_reg   <= (ad_ref[MAG_W-1:0] > MAG_W'(dead_band_reg));
                n_off_reg  <= MAG_W'(newest_reg - min_reg);
                m_mag_reg  <= ad_md[MAG_W-1:0];
                m_neg_reg  <= md[EXT_W-1];
                os_mag_reg <= os_abs[CFG_W-1:0];
                os_neg_reg <= os[CFG_W];
            end
            ST_CHECK:
            begin
                res_change_reg <= '0;
                res_empty_reg  <= empty_reg;
                q2_reg         <= '0;
            end
            ST_MUL:
            begin
                prod_reg     <= mul_p;
                prod_neg_reg <= phase_reg ? (m_neg_reg ^ os_neg_reg) : os_neg_reg;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (phase_reg)
                        q2_reg <= q_signed;
                    else
                        q1_reg <= q_signed;
                end
            end
            ST_FINISH:
            begin
                res_change_reg <= change_sat;
                res_empty_reg  <= 1'b0;
            end
            default: ;
        endcase
    end

    // shared divider
    rctn_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (max_reg - min_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_change_reg <= res_change_reg;
            m_empty_reg  <= res_empty_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_change_reg};
    assign m_tuser  = m_empty_reg;

endmodule

### verif/rc_throttle_channel_normalizer_tb.sv
// ----------------------------------------------------------------------------
// rc_throttle_channel_normalizer_tb
// Self-checking bench for the throttle channel normalizer. Commands go in as
// bursts of sample and bound-reload beats under several register settings,
// and results come back under a stalling receiver. A scoreboard class keeps
// its own copy of the tracked bounds and samples, predicts every result beat
// and compares it field by field.
// ----------------------------------------------------------------------------
module rc_throttle_channel_normalizer_tb;

    import rctn_pkg::*;

    // indexes that decode to no register
    localparam cfg_index_t REG_UNUSED_LOW  = 3'd6;
    localparam cfg_index_t REG_UNUSED_HIGH = 3'd7;

    // one predicted result beat
    typedef struct {
        logic [CHANGE_W-1:0] change;
        logic                empty;
    } throttle_result_t;

    // prediction of the block and store of expected result beats
    class throttle_scoreboard;
        bit                  mode_ret;
        bit [CFG_W-1:0]      center;
        bit [CFG_W-1:0]      dead_band;
        bit [CFG_W-1:0]      seed;
        bit [CFG_W-1:0]      out_lo;
        bit [CFG_W-1:0]      out_hi;
        bit [PULSE_W-1:0]    lo_seen;
        bit [PULSE_W-1:0]    hi_seen;
        bit [PULSE_W-1:0]    newest;
        bit [PULSE_W-1:0]    previous;
        throttle_result_t    expected_q[$];
        int                  errors;

        function new();
            mode_ret  = MODE_RETURNING_RST;
            center    = MIDDLE_POINT_RST;
            dead_band = DEAD_BAND_RST;
            seed      = BOUND_SEED_RST;
            out_lo    = OUT_FLOOR_RST;
            out_hi    = OUT_CEILING_RST;
            lo_seen   = BOUND_SEED_RST;
            hi_seen   = BOUND_SEED_RST;
            newest    = '0;
            previous  = '0;
            errors    = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_MODE_RETURNING: mode_ret  = value[0];
                REG_MIDDLE_POINT:   center    = value;
                REG_DEAD_BAND:      dead_band = value;
                REG_BOUND_SEED:     seed      = value;
                REG_OUT_FLOOR:      out_lo    = value;
                REG_OUT_CEILING:    out_hi    = value;
                default: ;
            endcase
        endfunction

        // linear map of the learned span onto the output range
        function longint scale(longint x);
            longint lo;
            longint span;
            longint outspan;
            lo      = lo_seen;
            span    = longint'(hi_seen) - lo;
            outspan = longint'(out_hi) - longint'(out_lo);
            if (span == 0)
                return longint'(out_lo);
            return (x - lo) * outspan / span + longint'(out_lo);
        endfunction

        function longint gap(longint a, longint b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void note_cmd(logic op, logic [PULSE_W-1:0] pw);
            longint           chg;
            throttle_result_t res;
            chg       = 0;
            res.empty = 1'b0;
            if (op == OP_BOUND_RESET)
            begin
                lo_seen = seed;
                hi_seen = seed;
            end
            else
            begin
                if (pw < lo_seen)
                    lo_seen = pw;
                if (pw > hi_seen)
                    hi_seen = pw;
                previous = newest;
                newest   = pw;
                if (hi_seen == lo_seen)
                    res.empty = 1'b1;
                else if (mode_ret)
                begin
                    if (gap(newest, center) > longint'(dead_band))
                        chg = scale(newest) - scale(center);
                end
                else if (gap(newest, previous) > longint'(dead_band))
                    chg = scale(newest) - scale(lo_seen);
            end
            // clamp to the reportable magnitude
            if (chg > CHANGE_LIMIT)
                chg = CHANGE_LIMIT;
            if (chg < -CHANGE_LIMIT)
                chg = -CHANGE_LIMIT;
            res.change = chg[CHANGE_W-1:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [23:0] data, logic user);
            throttle_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: tdata %h tuser %b", data, user);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (data[CHANGE_W-1:0] !== want.change)
            begin
                $error("throttle_change mismatch: expected %0d, got %0d",
                       $signed(want.change), $signed(data[CHANGE_W-1:0]));
                errors++;
            end
            if (data[23:CHANGE_W] !== '0)
            begin
                $error("tdata padding mismatch: expected 0, got %h", data[23:CHANGE_W]);
                errors++;
            end
            if (user !== want.empty)
            begin
                $error("range_empty mismatch: expected %b, got %b", want.empty, user);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_wr_en;
    cfg_index_t           cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    // toggled by the stimulus to ask the receiver for a long hold-off
    logic                 hold_tog;
    logic [PULSE_W-1:0]   last_pw;

    throttle_scoreboard board = new();

    rc_throttle_channel_normalizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    // receiver: checks result beats and stalls in stretches of its own
    initial
    begin : result_side
        int   stretch;
        int   style;
        int   hold_left;
        logic hold_seen;
        stretch   = 0;
        style     = 0;
        hold_left = 0;
        hold_seen = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (hold_tog !== hold_seen)
            begin
                hold_seen = hold_tog;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    style   = $urandom_range(0, 2);
                    stretch = $urandom_range(5, 60);
                end
                stretch--;
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [15:0] clip16(int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    // register value: extremes now and then, otherwise random or typical
    function automatic logic [15:0] pick_setting(int typ_lo, int typ_hi);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(typ_lo, typ_hi));
        endcase
    endfunction

    // one command beat; tvalid stays high after acceptance
    task automatic send_beat(logic op, logic [15:0] pw);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= pw;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_cmd(op, pw);
        if (op == OP_SAMPLE)
            last_pw = pw;
    endtask

    // sender gap with junk on the data lines
    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n)
            begin
                s_tdata <= 16'($urandom);
                s_tuser <= 1'($urandom_range(0, 1));
                @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        board.write_reg(idx, value);
    endtask

    // full register set, written only once the block is idle
    task automatic apply_settings(logic [15:0] mode_word, logic [15:0] mid,
                                  logic [15:0] db, logic [15:0] seed,
                                  logic [15:0] lo, logic [15:0] hi, bit poke_unused);
        wait_drained();
        write_reg(REG_MODE_RETURNING, mode_word);
        write_reg(REG_MIDDLE_POINT, mid);
        write_reg(REG_DEAD_BAND, db);
        write_reg(REG_BOUND_SEED, seed);
        write_reg(REG_OUT_FLOOR, lo);
        write_reg(REG_OUT_CEILING, hi);
        if (poke_unused)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_HIGH : REG_UNUSED_LOW,
                      16'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random_phase(int count, bit with_gaps, bit hold_now, bit pause_now);
        int          burst;
        int          anchor;
        int          db;
        logic        op;
        logic [15:0] pw;
        anchor = $urandom_range(1000, 2000);
        burst  = $urandom_range(1, 24);
        if (hold_now)
            hold_tog <= ~hold_tog;
        for (int i = 0; i < count; i++)
        begin
            if (pause_now && i == count / 2)
                wait_drained();
            db = int'(board.dead_band);
            op = OP_SAMPLE;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pw = clip16(anchor + $urandom_range(0, 1200) - 600);
                4, 5:       pw = clip16(int'(last_pw) + $urandom_range(0, 2 * db + 4) - db - 2);
                6, 7:       pw = 16'($urandom);
                8:
                begin
                    case ($urandom_range(0, 3))
                        0:       pw = 16'd0;
                        1:       pw = 16'hFFFF;
                        2:       pw = clip16(int'(board.center) + db + 1);
                        default: pw = clip16(int'(board.center) - db);
                    endcase
                end
                default:
                begin
                    op = OP_BOUND_RESET;
                    pw = 16'($urandom);
                end
            endcase
            send_beat(op, pw);
            // burst and gap pattern of the sender
            if (with_gaps && !hold_now)
            begin
                burst--;
                if (burst == 0)
                begin
                    idle_cycles($urandom_range(0, 12));
                    burst = $urandom_range(1, 24);
                end
            end
        end
    endtask

    // main stimulus
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_SAMPLE;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_MODE_RETURNING;
        cfg_wdata <= '0;
        hold_tog  <= 1'b0;
        last_pw    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty range, dead band edges, far samples, reload
        send_beat(OP_SAMPLE, 16'd1500);
        send_beat(OP_SAMPLE, 16'd1505);
        send_beat(OP_SAMPLE, 16'd0);
        send_beat(OP_SAMPLE, 16'hFFFF);
        send_beat(OP_SAMPLE, 16'd1511);
        send_beat(OP_SAMPLE, 16'd1490);
        send_beat(OP_BOUND_RESET, 16'hA5A5);
        send_beat(OP_SAMPLE, 16'd1500);

        // fixed mode, inverted output range, zero dead band and seed
        apply_settings(16'hFFFE, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b1);
        send_beat(OP_BOUND_RESET, 16'd0);
        send_beat(OP_SAMPLE, 16'd0);
        send_beat(OP_SAMPLE, 16'hFFFF);
        send_beat(OP_SAMPLE, 16'hFFFF);
        send_beat(OP_SAMPLE, 16'd32768);
        send_beat(OP_SAMPLE, 16'd1);

        // center far above a one-wide span: negative clamp
        apply_settings(16'd1, 16'hFFFF, 16'd0, 16'd100, 16'd0, 16'hFFFF, 1'b0);
        send_beat(OP_BOUND_RESET, 16'hFFFF);
        send_beat(OP_SAMPLE, 16'd101);

        // center far below a one-wide span: positive clamp
        apply_settings(16'd1, 16'd0, 16'd0, 16'd65534, 16'd0, 16'hFFFF, 1'b0);
        send_beat(OP_BOUND_RESET, 16'd0);
        send_beat(OP_SAMPLE, 16'hFFFF);

        // widest dead band hides every change
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_beat(OP_BOUND_RESET, 16'd0);
        send_beat(OP_SAMPLE, 16'd0);
        send_beat(OP_SAMPLE, 16'hFFFF);

        // random phases under fresh settings
        for (int ph = 0; ph < 9; ph++)
        begin
            apply_settings({15'($urandom), 1'($urandom_range(0, 1))},
                           pick_setting(1000, 2000), pick_setting(0, 40),
                           pick_setting(1000, 2000), pick_setting(0, 1000),
                           pick_setting(0, 2000), ($urandom_range(0, 2) == 0));
            if ($urandom_range(0, 1))
                send_beat(OP_BOUND_RESET, 16'($urandom));
            run_random_phase(70, (ph != 1 && ph != 6), (ph == 2), (ph == 5));
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
